[rtl/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/dstb_pkg.sv]
package dstb_pkg;

  localparam int unsigned LOGIT_W  = 16;
  localparam int unsigned Q16_W    = 16;
  localparam int unsigned EXP_W    = 17;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned COORD_W  = 14;
  localparam int unsigned CLASS_W  = 3;
  localparam int unsigned NAMED_W  = 4;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned EXP_SHIFT = 4;

  localparam logic [SUM_W-1:0] ONE_Q16   = 20'd65536;
  localparam logic [SUM_W-1:0] SUM_LIMIT = 20'hFFFFF;
  localparam logic [31:0]      EXP_RATIO_Q32 = 32'd4034748382;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NAMED_CLASSES   = 3'd0,
    REG_DEFAULT_THRESH  = 3'd1,
    REG_OWN_MASK        = 3'd2,
    REG_THRESH_LOW      = 3'd3,
    REG_THRESH_HIGH     = 3'd4,
    REG_IMAGE_WIDTH     = 3'd5,
    REG_IMAGE_HEIGHT    = 3'd6
  } cfg_reg_t;

  // entry k of the exp(-k/16) table in Q1.16, entry 0 is exactly one
  function automatic logic [EXP_W-1:0] exp_entry(input int k);
    logic [95:0] v;
    v = 96'h1_0000_0000;
    for (int i = 1; i <= k; i++) begin
      v = (v * {64'd0, EXP_RATIO_Q32} + 96'h8000_0000) >> 32;
    end
    return EXP_W'((v + 96'd32768) >> 16);
  endfunction

endpackage

[rtl/dstb_if.sv]
interface dstb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] logit;
  logic               last_logit;
  logic [15:0]        center_x;
  logic [15:0]        center_y;
  logic [15:0]        box_width;
  logic [15:0]        box_height;

  modport source (output valid, logit, last_logit, center_x, center_y, box_width,
                  box_height, input ready);
  modport sink (input valid, logit, last_logit, center_x, center_y, box_width,
                box_height, output ready);
endinterface

interface dstb_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         class_index;
  logic [15:0]        confidence;
  logic signed [13:0] left;
  logic signed [13:0] top;
  logic signed [13:0] right;
  logic signed [13:0] bottom;

  modport source (output valid, class_index, confidence, left, top, right, bottom,
                  input ready);
  modport sink (input valid, class_index, confidence, left, top, right, bottom,
                output ready);
endinterface

[rtl/dstb_recip.sv]
module dstb_recip (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [19:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  import dstb_pkg::*;

  logic        busy;
  logic [4:0]  steps;
  logic [20:0] rem;
  logic [16:0] quo;
  logic [20:0] trial;
  logic        fits;

  // restoring division of 2^32, one quotient bit a cycle
  assign trial = {rem[19:0], 1'b0};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (divisor[19:16] == 4'd0) begin
          // below one: quotient saturates
          quo  <= 17'h0FFFF;
          done <= 1'b1;
        end else begin
          busy  <= 1'b1;
          steps <= 5'd17;
          rem   <= 21'd32768;
          quo   <= '0;
        end
      end else if (busy) begin
        if (fits) begin
          rem <= trial - {1'b0, divisor};
        end else begin
          rem <= trial;
        end
        quo   <= {quo[15:0], fits};
        steps <= steps - 5'd1;
        if (steps == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo[16] ? 16'hFFFF : quo[15:0];

  `include "assert_macros.svh"
  `ASSERT_CLK(a_no_restart, busy |-> !start, "divider restarted while busy")
  `ASSERT_CLK(a_rem_below, busy |-> (rem < {1'b0, divisor}), "remainder not below divisor")
  `ASSERT_CLK(a_done_end, (busy && steps == 5'd1) |=> (done && !busy), "divider did not finish")
endmodule

[rtl/detection_softmax_threshold_box_top.sv]
// detection post-processing: softmax, argmax, threshold and box scaling
// det_in takes one signed Q8.8 class logit per request, classes in index order;
// last_logit marks the final logit of a row, and on that request the Q0.16 box
// fields are used. det_out gives at most one detection per row: class, Q0.16
// confidence and four pixel corners.
// cfg_write_enable/cfg_index/cfg_data write the registers; the user must write them
// only while idle, the block itself does not enforce it. a logit is taken in idle;
// the first of a row, or one past the class limit, needs no more, any other goes on
// to a table read, a shared multiply when it is a new maximum, and a sum update; the
// next logit is taken after that. a row end starts the bit-serial reciprocal, takes
// the quotient, makes the decision, computes the four corners on the shared multiplier
// and loads the output; a dropped row frees the input after the decision.
// det_in.ready is high only while the sequencer is idle.
// the result sits in an output register: while the receiver stalls the block
// still takes logits of the next row and holds only before a new result.
// reset is synchronous: row state clears, registers go to their reset values,
// the output register empties; no clearing pass is needed.
module detection_softmax_threshold_box_top #(
  parameter int MAX_CLASSES     = 8,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  dstb_in_if.sink                       det_in,
  dstb_out_if.source                    det_out,
  input  logic                          cfg_write_enable,
  input  logic [dstb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dstb_pkg::CFG_W-1:0]    cfg_data
);
  import dstb_pkg::*;

  localparam int CW = $clog2(MAX_CLASSES + 1);
  localparam int IW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int AW = $clog2(EXP_TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_MUL, S_SUM, S_DIV, S_DWAIT, S_DEC, S_BOXM, S_BOXS, S_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [NAMED_W-1:0] named_classes;
  logic [Q16_W-1:0]   default_threshold;
  logic [7:0]         own_threshold_mask;
  logic [63:0]        thresholds_low;
  logic [63:0]        thresholds_high;
  logic [SIZE_W-1:0]  image_width;
  logic [SIZE_W-1:0]  image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      named_classes      <= 4'd8;
      default_threshold  <= 16'd32768;
      own_threshold_mask <= '0;
      thresholds_low     <= '0;
      thresholds_high    <= '0;
      image_width        <= 13'd640;
      image_height       <= 13'd480;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_NAMED_CLASSES:  named_classes      <= cfg_data[NAMED_W-1:0];
        REG_DEFAULT_THRESH: default_threshold  <= cfg_data[Q16_W-1:0];
        REG_OWN_MASK:       own_threshold_mask <= cfg_data[7:0];
        REG_THRESH_LOW:     thresholds_low     <= cfg_data;
        REG_THRESH_HIGH:    thresholds_high    <= cfg_data;
        REG_IMAGE_WIDTH:    image_width        <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:   image_height       <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // exp table as constant logic
  logic [EXP_W-1:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [EXP_W-1:0] ENTRY = exp_entry(k);
    assign exp_rom[k] = ENTRY;
  end

  // row state
  logic signed [LOGIT_W-1:0] running_max;
  logic [SUM_W-1:0]          exp_sum;
  logic [IW-1:0]             best_index;
  logic [CW-1:0]             class_counter;

  // latched request
  logic signed [LOGIT_W-1:0] x;
  logic                      last;
  logic [15:0]               cx, cy, bw, bh;

  logic                      greater;
  logic [12:0]               exp_idx;
  logic [EXP_W-1:0]          exp_q;
  logic signed [38:0]        prod;
  logic [1:0]                corner;
  logic [Q16_W-1:0]          conf;
  logic signed [COORD_W-1:0] coord [4];

  // difference against the running maximum
  logic signed [LOGIT_W:0] x_ext, max_ext, diff;
  logic                    in_greater;
  assign x_ext      = {det_in.logit[LOGIT_W-1], det_in.logit};
  assign max_ext    = {running_max[LOGIT_W-1], running_max};
  assign in_greater = x_ext > max_ext;
  assign diff       = in_greater ? (x_ext - max_ext) : (max_ext - x_ext);

  // shared multiplier operands
  logic signed [20:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [18:0] num;
  logic [SIZE_W-1:0]  size_sel;

  always_comb begin
    unique case (corner)
      2'd0: num = 19'(2 * {3'd0, cx}) - {3'd0, bw};
      2'd1: num = 19'(2 * {3'd0, cy}) - {3'd0, bh};
      2'd2: num = 19'(2 * {3'd0, cx}) + {3'd0, bw};
      default: num = 19'(2 * {3'd0, cy}) + {3'd0, bh};
    endcase
    size_sel = corner[0] ? image_height : image_width;
    if (state == S_MUL) begin
      mul_a = {1'b0, exp_sum};
      mul_b = {1'b0, exp_q};
    end else begin
      mul_a = {{2{num[18]}}, num};
      mul_b = {5'd0, size_sel};
    end
  end

  // rescaled and accumulated sums
  logic [21:0] scaled_sum;
  logic [20:0] added_sum;
  assign scaled_sum = {1'b0, prod[36:16]} + {2'd0, ONE_Q16};
  assign added_sum  = {1'b0, exp_sum} + {4'd0, exp_q};

  // truncate toward zero, then clamp
  logic signed [38:0] rounded;
  logic signed [21:0] scaled;
  logic signed [COORD_W-1:0] clamped;
  assign rounded = prod[38] ? (prod + 39'sd131071) : prod;
  assign scaled  = rounded[38:17];
  assign clamped = (scaled > 22'sd8191)  ? 14'sd8191 :
                   (scaled < -22'sd8192) ? -14'sd8192 : scaled[COORD_W-1:0];

  // threshold of the winning class
  logic [CLASS_W-1:0] cls;
  logic [63:0]        bank;
  logic [Q16_W-1:0]   thresh;
  logic               drop;
  assign cls    = CLASS_W'(best_index);
  assign bank   = cls[2] ? thresholds_high : thresholds_low;
  assign thresh = own_threshold_mask[cls] ? bank[16*cls[1:0] +: 16] : default_threshold;
  assign drop   = ({{(NAMED_W-IW){1'b0}}, best_index} >= named_classes) || (conf < thresh);

  logic        div_start, div_done;
  logic [15:0] div_quot;

  dstb_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (exp_sum),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign div_start    = state == S_DIV;
  assign det_in.ready = state == S_IDLE;

  logic in_fire;
  assign in_fire = det_in.valid && det_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_max   <= '0;
      exp_sum       <= '0;
      best_index    <= '0;
      class_counter <= '0;
      corner        <= '0;
      det_out.valid <= 1'b0;
    end else begin
      // the emit state sets valid itself
      if (det_out.valid && det_out.ready && state != S_EMIT) begin
        det_out.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            x       <= det_in.logit;
            last    <= det_in.last_logit;
            cx      <= det_in.center_x;
            cy      <= det_in.center_y;
            bw      <= det_in.box_width;
            bh      <= det_in.box_height;
            greater <= in_greater;
            exp_idx <= diff[LOGIT_W:EXP_SHIFT];
            if (class_counter < CW'(MAX_CLASSES)) begin
              if (class_counter == '0) begin
                running_max   <= det_in.logit;
                exp_sum       <= ONE_Q16;
                best_index    <= '0;
                class_counter <= CW'(1);
                state         <= det_in.last_logit ? S_DIV : S_IDLE;
              end else begin
                state <= S_LOOK;
              end
            end else begin
              // surplus logit: ignored, but may still end the row
              state <= det_in.last_logit ? S_DIV : S_IDLE;
            end
          end
        end
        S_LOOK: begin
          if ({19'd0, exp_idx} < 32'(EXP_TABLE_DEPTH)) begin
            exp_q <= exp_rom[exp_idx[AW-1:0]];
          end else begin
            exp_q <= '0;
          end
          state <= greater ? S_MUL : S_SUM;
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_SUM;
        end
        S_SUM: begin
          if (greater) begin
            exp_sum     <= (scaled_sum > {2'd0, SUM_LIMIT}) ? SUM_LIMIT : scaled_sum[SUM_W-1:0];
            running_max <= x;
            best_index  <= class_counter[IW-1:0];
          end else begin
            exp_sum <= (added_sum > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : added_sum[SUM_W-1:0];
          end
          class_counter <= class_counter + CW'(1);
          state         <= last ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            conf  <= div_quot;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          corner <= '0;
          if (drop) begin
            running_max   <= '0;
            exp_sum       <= '0;
            best_index    <= '0;
            class_counter <= '0;
            state         <= S_IDLE;
          end else begin
            state <= S_BOXM;
          end
        end
        S_BOXM: begin
          prod  <= mul_a * mul_b;
          state <= S_BOXS;
        end
        S_BOXS: begin
          coord[corner] <= clamped;
          corner        <= corner + 2'd1;
          state         <= (corner == 2'd3) ? S_EMIT : S_BOXM;
        end
        S_EMIT: begin
          if (!det_out.valid || det_out.ready) begin
            det_out.valid       <= 1'b1;
            det_out.class_index <= cls;
            det_out.confidence  <= conf;
            det_out.left        <= coord[0];
            det_out.top         <= coord[1];
            det_out.right       <= coord[2];
            det_out.bottom      <= coord[3];
            running_max   <= '0;
            exp_sum       <= '0;
            best_index    <= '0;
            class_counter <= '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_sum_floor, (class_counter != '0) |-> (exp_sum >= ONE_Q16),
              "softmax sum below one inside a row")
  `ASSERT_CLK(a_count_max, class_counter <= CW'(MAX_CLASSES), "class counter overrun")
  `ASSERT_CLK(a_out_hold, (det_out.valid && !det_out.ready) |=>
              (det_out.valid && $stable(det_out.confidence)),
              "result changed while the receiver stalled")
endmodule

[dv/tb_detection_softmax_threshold_box_top.sv]
module tb_detection_softmax_threshold_box_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dstb_pkg::*;

  typedef struct packed {
    logic [2:0]         cls;
    logic [15:0]        conf;
    logic signed [13:0] x1;
    logic signed [13:0] y1;
    logic signed [13:0] x2;
    logic signed [13:0] y2;
  } detection_t;

  typedef struct {
    logic signed [15:0] lg;
    bit                 last;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [15:0]        bw;
    logic [15:0]        bh;
    bit                 typed;
    detection_t         det;
  } logit_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  dstb_in_if din ();
  dstb_out_if dout ();

  detection_softmax_threshold_box_top dut (
    .clk(clk), .rst(rst), .det_in(din), .det_out(dout),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of the block
  logic [16:0] exp_q16 [256];
  logic [3:0]  named_cnt;
  logic [15:0] dflt_thr;
  logic [7:0]  own_mask;
  logic [63:0] thr_lo, thr_hi;
  logic [12:0] img_w, img_h;
  int          row_max;
  longint      row_sum;
  int unsigned row_best, row_count;

  detection_t  detection_q[$];
  bit          cur_typed = 1'b0;
  detection_t  cur_det;
  int          errors = 0;
  int          items_sent = 0, rows_sent = 0, dets_seen = 0;
  bit          hold_off = 1'b0, quiet = 1'b0;
  int          gap_odds = 6;

  function automatic longint exp_of(longint diff);
    longint k;
    k = diff >>> 4;
    if (k >= 256) return 0;
    return exp_q16[k];
  endfunction

  function automatic logic signed [13:0] to_pixels(longint num, longint size);
    longint v;
    v = (num * size) / 131072;
    if (v > 8191) v = 8191;
    if (v < -8192) v = -8192;
    return v[13:0];
  endfunction

  // one accepted logit; returns 1 when the row ends in a detection
  function automatic bit absorb_logit(logic signed [15:0] lg, bit last, logic [15:0] cx,
                                      logic [15:0] cy, logic [15:0] bw, logic [15:0] bh,
                                      output detection_t det);
    int          x;
    longint      s, conf, thr;
    int unsigned cls;
    x = lg;
    det = '0;
    if (row_count < 8) begin
      if (row_count == 0) begin
        row_max = x;
        row_sum = 65536;
        row_best = 0;
      end else if (x > row_max) begin
        s = ((row_sum * exp_of(x - row_max)) >> 16) + 65536;
        row_sum = s > 1048575 ? 1048575 : s;
        row_max = x;
        row_best = row_count;
      end else begin
        s = row_sum + exp_of(row_max - x);
        row_sum = s > 1048575 ? 1048575 : s;
      end
      row_count++;
    end
    if (!last) return 1'b0;
    if (row_sum == 0) conf = 65535;
    else begin
      conf = 64'h1_0000_0000 / row_sum;
      if (conf > 65535) conf = 65535;
    end
    cls = row_best & 7;
    s = row_best;
    row_max = 0; row_sum = 0; row_best = 0; row_count = 0;
    if (s >= named_cnt) return 1'b0;
    if (own_mask[cls]) thr = (cls < 4) ? thr_lo[16*(cls%4) +: 16] : thr_hi[16*(cls%4) +: 16];
    else thr = dflt_thr;
    if (conf < thr) return 1'b0;
    det.cls  = cls[2:0];
    det.conf = conf[15:0];
    det.x1   = to_pixels(2 * longint'(cx) - longint'(bw), img_w);
    det.y1   = to_pixels(2 * longint'(cy) - longint'(bh), img_h);
    det.x2   = to_pixels(2 * longint'(cx) + longint'(bw), img_w);
    det.y2   = to_pixels(2 * longint'(cy) + longint'(bh), img_h);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    detection_t d, got;
    if (!rst) begin
      if (din.valid && din.ready) begin
        if (absorb_logit(din.logit, din.last_logit, din.center_x, din.center_y,
                         din.box_width, din.box_height, d) && !cur_typed)
          detection_q.insert(detection_q.size(), d);
        if (cur_typed) detection_q.insert(detection_q.size(), cur_det);
      end
      if (dout.valid && dout.ready) begin
        got = '{dout.class_index, dout.confidence, dout.left, dout.top, dout.right,
                dout.bottom};
        dets_seen++;
        if (detection_q.size() == 0) begin
          $error("detection with nothing expected: class %0d conf %0d", got.cls, got.conf);
          errors++;
        end else begin
          d = detection_q.pop_front();
          if (got.cls != d.cls) begin
            $error("class_index: expected %0d, got %0d", d.cls, got.cls); errors++;
          end
          if (got.conf != d.conf) begin
            $error("confidence: expected %0d, got %0d", d.conf, got.conf); errors++;
          end
          if (got.x1 != d.x1) begin
            $error("left: expected %0d, got %0d", d.x1, got.x1); errors++;
          end
          if (got.y1 != d.y1) begin
            $error("top: expected %0d, got %0d", d.y1, got.y1); errors++;
          end
          if (got.x2 != d.x2) begin
            $error("right: expected %0d, got %0d", d.x2, got.x2); errors++;
          end
          if (got.y2 != d.y2) begin
            $error("bottom: expected %0d, got %0d", d.y2, got.y2); errors++;
          end
        end
      end
    end
  end

  // receiver
  initial begin
    dout.ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_off) begin
        dout.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        dout.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        dout.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  task automatic send_logit(logit_row_t r);
    if (!quiet && gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
      din.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    din.valid      <= 1'b1;
    din.logit      <= r.lg;
    din.last_logit <= r.last;
    din.center_x   <= r.cx;
    din.center_y   <= r.cy;
    din.box_width  <= r.bw;
    din.box_height <= r.bh;
    cur_typed      <= r.typed;
    cur_det        <= r.det;
    do @(posedge clk); while (!din.ready);
    items_sent++;
    if (r.last) rows_sent++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value;
    @(posedge clk);
    case (idx)
      REG_NAMED_CLASSES:  named_cnt = value[3:0];
      REG_DEFAULT_THRESH: dflt_thr  = value[15:0];
      REG_OWN_MASK:       own_mask  = value[7:0];
      REG_THRESH_LOW:     thr_lo    = value;
      REG_THRESH_HIGH:    thr_hi    = value;
      REG_IMAGE_WIDTH:    img_w     = value[12:0];
      REG_IMAGE_HEIGHT:   img_h     = value[12:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [3:0] n, logic [15:0] d, logic [7:0] m, logic [63:0] lo,
                            logic [63:0] hi, logic [12:0] w, logic [12:0] h);
    din.valid <= 1'b0;
    // let the last request reach the checker, then wait for an idle block
    @(posedge clk);
    wait (detection_q.size() == 0 && din.ready);
    repeat (40) @(posedge clk);
    write_reg(REG_NAMED_CLASSES, n);
    write_reg(REG_DEFAULT_THRESH, d);
    write_reg(REG_OWN_MASK, m);
    write_reg(REG_THRESH_LOW, lo);
    write_reg(REG_THRESH_HIGH, hi);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_write_enable <= 1'b0;
  endtask

  function automatic logic [12:0] pick_size();
    case ($urandom_range(0, 4))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'd8191;
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic random_row();
    logit_row_t r;
    int n, style, base, win, v;
    bit edges;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
    style = $urandom_range(0, 3);
    base = $urandom_range(0, 65535) - 32768;
    win = $urandom_range(0, n - 1);
    edges = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < n; k++) begin
      case (style)
        0: v = $urandom_range(0, 65535) - 32768;
        1: v = base + ((k == win) ? $urandom_range(1024, 8000) : -$urandom_range(0, 2000));
        2: v = base + $urandom_range(0, 64);
        default: v = base;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      r.lg = 16'(v);
      r.last = (k == n - 1);
      r.cx = edges ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
      r.cy = edges ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
      r.bw = edges ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
      r.bh = edges ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
      r.typed = 1'b0;
      r.det = '0;
      send_logit(r);
    end
  endtask

  logit_row_t directed[$];

  function automatic void add_row(logit_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    longint unsigned acc, ratio;
    logic [127:0] wide;
    din.valid = 1'b0;
    din.logit = '0;
    din.last_logit = 1'b0;
    din.center_x = '0;
    din.center_y = '0;
    din.box_width = '0;
    din.box_height = '0;

    ratio = 64'd4034748382;
    acc = 64'h1_0000_0000;
    for (int k = 0; k < 256; k++) begin
      if (k > 0) begin
        wide = 128'(acc) * 128'(ratio) + 128'h8000_0000;
        acc = wide[95:32];
      end
      exp_q16[k] = 17'((acc + 64'd32768) >> 16);
    end
    named_cnt = 4'd8; dflt_thr = 16'd32768; own_mask = '0;
    thr_lo = '0; thr_hi = '0; img_w = 13'd640; img_h = 13'd480;
    row_max = 0; row_sum = 0; row_best = 0; row_count = 0;

    // single logit rows at reset settings, box extremes
    add_row('{16'sd0, 1, 16'd32768, 16'd32768, 16'hFFFF, 16'hFFFF, 1,
              '{3'd0, 16'd65535, 14'sd0, 14'sd0, 14'sd639, 14'sd479}});
    add_row('{-16'sd32768, 1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1,
              '{3'd0, 16'd65535, -14'sd319, 14'sd479, 14'sd319, 14'sd479}});
    add_row('{16'sd32767, 1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1,
              '{3'd0, 16'd65535, 14'sd639, -14'sd239, 14'sd639, 14'sd239}});
    // difference beyond the table, falling then rising
    add_row('{16'sd32767, 0, 0, 0, 0, 0, 0, '0});
    add_row('{-16'sd32768, 1, 0, 0, 0, 0, 1, '{3'd0, 16'd65535, 0, 0, 0, 0}});
    add_row('{-16'sd32768, 0, 0, 0, 0, 0, 0, '0});
    add_row('{16'sd32767, 1, 0, 0, 0, 0, 1, '{3'd1, 16'd65535, 0, 0, 0, 0}});
    // tie keeps the earlier class, confidence just at threshold
    add_row('{16'sd256, 0, 0, 0, 0, 0, 0, '0});
    add_row('{16'sd256, 1, 0, 0, 0, 0, 1, '{3'd0, 16'd32768, 0, 0, 0, 0}});
    // rising row exercises the rescale
    add_row('{16'sd0, 0, 0, 0, 0, 0, 0, '0});
    add_row('{16'sd256, 0, 0, 0, 0, 0, 0, '0});
    add_row('{16'sd512, 1, 16'd20000, 16'd30000, 16'd1000, 16'd2000, 0, '0});
    // surplus logits, the big one past the eighth is ignored
    for (int k = 0; k < 9; k++)
      add_row('{(k == 8) ? 16'sd32767 : 16'sd0, k == 8, 0, 0, 0, 0, 0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_odds = 4;
    foreach (directed[i]) send_logit(directed[i]);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(4'd8, 16'd0, 8'h00, {$urandom, $urandom}, {$urandom, $urandom},
                      13'd640, 13'd480);
        1: set_config(4'd15, 16'hFFFF, 8'hFF, {$urandom, $urandom}, {$urandom, $urandom},
                      13'd4096, 13'd1);
        2: set_config(4'd0, 16'd0, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 13'd8191, 13'd8191);
        3: set_config(4'd8, 16'd16384, 8'($urandom), {4{16'($urandom_range(0, 30000))}},
                      {4{16'($urandom_range(0, 30000))}}, 13'd1, 13'd4096);
        4: set_config(4'd1, 16'd0, 8'h00, 64'd0, 64'd0, 13'd0, 13'd0);
        5: set_config(4'($urandom_range(0, 15)), 16'($urandom_range(0, 40000)), 8'($urandom),
                      {$urandom, $urandom}, {$urandom, $urandom}, pick_size(), pick_size());
        6: set_config(4'd4, 16'd20000, 8'hAA, {$urandom, $urandom}, {$urandom, $urandom},
                      13'd8191, 13'd8191);
        default: set_config(4'd8, 16'd0, 8'hFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                            13'd1920, 13'd1080);
      endcase
      gap_odds = (p % 3 == 0) ? 0 : $urandom_range(2, 8);
      quiet = (p == 7);
      for (int n = items_sent + 200; items_sent < n; ) begin
        if (p == 3 && items_sent + 200 == n) hold_off = 1'b1;
        random_row();
      end
    end

    din.valid <= 1'b0;
    @(posedge clk);
    wait (detection_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("%0d logits in %0d rows over eight register settings, %0d detections checked",
             items_sent, rows_sent, dets_seen);
    if (errors == 0 && detection_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout waiting for the block");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
